### sv/phpd_pkg.sv
// shared types and constants for the piezo hit peak detector
// used by every module of the block, depends on nothing
package phpd_pkg;

  localparam int RAW_W   = 12;
  localparam int TIME_W  = 64;
  localparam int LEVEL_W = 7;
  localparam int WIN_W   = 20;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;
  localparam logic [LEVEL_W-1:0] VEL_MIN   = 7'd1;
  localparam logic [RAW_W:0]     ADC_FULL  = 13'd4095;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK       = 2'd3;

  localparam logic [LEVEL_W-1:0] TRIGGER_RESET    = 7'd20;
  localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 7'd27;
  localparam logic [WIN_W-1:0]   SCAN_RESET       = 20'd6300;
  localparam logic [WIN_W-1:0]   MASK_RESET       = 20'd24600;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_level;
    logic [LEVEL_W-1:0] full_scale_level;
    logic [WIN_W-1:0]   scan_window_us;
    logic [WIN_W-1:0]   mask_window_us;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### sv/phpd_front.sv
// front part: takes samples, scales them, runs hit start, mask and scan window
// depends on phpd_pkg; pushes the peak of each finished hit into the queue
module phpd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  phpd_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [phpd_pkg::RAW_W-1:0]   raw_sample,
  input  logic [phpd_pkg::TIME_W-1:0]  now_us,
  input  phpd_pkg::q_status_t          q_stat,
  output logic                         q_push,
  output logic [phpd_pkg::LEVEL_W-1:0] q_wdata
);

  typedef enum logic {F_IDLE, F_EVAL} fstate_t;

  fstate_t                        state;
  logic                           scanning;
  logic [phpd_pkg::LEVEL_W-1:0]   peak;
  logic [phpd_pkg::TIME_W-1:0]    start_time;
  logic [phpd_pkg::TIME_W-1:0]    end_time;
  logic [phpd_pkg::LEVEL_W-1:0]   level;
  logic [phpd_pkg::TIME_W-1:0]    now;

  logic [phpd_pkg::RAW_W+6:0]     prod;
  logic [phpd_pkg::LEVEL_W-1:0]   q0;
  logic [phpd_pkg::RAW_W:0]       rem;
  logic [phpd_pkg::LEVEL_W-1:0]   level_next;

  logic [phpd_pkg::TIME_W-1:0]    d_end;
  logic [phpd_pkg::TIME_W-1:0]    d_start;
  logic                           start_hit;
  logic                           masked;
  logic                           active;
  logic                           window_done;
  logic                           emit;
  logic [phpd_pkg::LEVEL_W-1:0]   peak_eff;

  // raw*127/4095: quotient estimate by shift, then one correction
  always_comb begin
    prod       = {raw_sample, 7'd0} - {7'd0, raw_sample};
    q0         = prod[phpd_pkg::RAW_W+6:phpd_pkg::RAW_W];
    rem        = {1'b0, prod[phpd_pkg::RAW_W-1:0]} + {6'd0, q0};
    level_next = (rem >= phpd_pkg::ADC_FULL) ? q0 + 7'd1 : q0;
  end

  always_comb begin
    d_end       = now - end_time;
    d_start     = now - start_time;
    start_hit   = !scanning && (level > cfg.trigger_level);
    masked      = start_hit && (d_end[phpd_pkg::TIME_W-1:phpd_pkg::WIN_W] == '0)
                  && (d_end[phpd_pkg::WIN_W-1:0] < cfg.mask_window_us);
    active      = scanning || start_hit;
    if (start_hit) begin
      peak_eff    = level;
      window_done = (cfg.scan_window_us == '0);
    end else begin
      peak_eff    = (level > peak) ? level : peak;
      window_done = (d_start >= phpd_pkg::TIME_W'(cfg.scan_window_us));
    end
    emit = (state == F_EVAL) && active && !masked && window_done;
  end

  assign in_ready = (state == F_IDLE);
  assign q_push   = emit && !q_stat.full;
  assign q_wdata  = peak_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      scanning   <= 1'b0;
      peak       <= '0;
      start_time <= '0;
      end_time   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            level <= level_next;
            now   <= now_us;
            state <= F_EVAL;
          end
        end
        F_EVAL: begin
          if (!(emit && q_stat.full)) begin
            state <= F_IDLE;
            if (!masked) begin
              if (emit) begin
                scanning <= 1'b0;
                end_time <= now;
                peak     <= peak_eff;
              end else if (active) begin
                scanning <= 1'b1;
                peak     <= peak_eff;
                if (start_hit) begin
                  start_time <= now;
                end
              end
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### sv/phpd_queue.sv
// short queue of hit peaks between the front and back parts
// depends on phpd_pkg for the status struct
module phpd_queue #(
  parameter int DEPTH = phpd_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int WIDTH = phpd_pkg::LEVEL_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output phpd_pkg::q_status_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rdata      = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/phpd_back.sv
// back part: turns a hit peak into a velocity with a bit-per-cycle divider
// depends on phpd_pkg; holds the result in an output register until taken
module phpd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  phpd_pkg::cfg_t               cfg,
  input  phpd_pkg::q_status_t          q_stat,
  input  logic [phpd_pkg::LEVEL_W-1:0] q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [phpd_pkg::LEVEL_W-1:0] hit_velocity
);

  localparam int NUM_W = 2 * phpd_pkg::LEVEL_W;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

  bstate_t                      state;
  logic [2:0]                   cnt;
  logic [NUM_W-1:0]             rem;
  logic [phpd_pkg::LEVEL_W-1:0] quo;
  logic [phpd_pkg::LEVEL_W-1:0] vel;

  logic [phpd_pkg::LEVEL_W-1:0] span;
  logic [phpd_pkg::LEVEL_W-1:0] diff;
  logic [NUM_W-1:0]             num;
  logic [NUM_W-1:0]             span_sh;
  logic                         fits;
  logic [phpd_pkg::LEVEL_W-1:0] quo_next;

  always_comb begin
    span     = cfg.full_scale_level - cfg.trigger_level;
    diff     = q_rdata - cfg.trigger_level;
    num      = {diff, 7'd0} - {7'd0, diff};
    span_sh  = {7'd0, span} << cnt;
    fits     = (rem >= span_sh);
    quo_next = {quo[phpd_pkg::LEVEL_W-2:0], fits};
  end

  assign q_pop        = (state == B_IDLE) && !q_stat.empty;
  assign out_valid    = (state == B_OUT);
  assign hit_velocity = vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            if (cfg.full_scale_level <= cfg.trigger_level) begin
              vel   <= phpd_pkg::LEVEL_MAX;
              state <= B_OUT;
            end else if (q_rdata <= cfg.trigger_level) begin
              vel   <= phpd_pkg::VEL_MIN;
              state <= B_OUT;
            end else if (num >= {span, 7'd0}) begin
              // quotient of 128 or more saturates
              vel   <= phpd_pkg::LEVEL_MAX;
              state <= B_OUT;
            end else begin
              rem   <= num;
              quo   <= '0;
              cnt   <= 3'd6;
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (fits) begin
            rem <= rem - span_sh;
          end
          quo <= quo_next;
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            vel   <= (quo_next == '0) ? phpd_pkg::VEL_MIN : quo_next;
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

### sv/piezo_hit_peak_detector.sv
// top level of the piezo hit peak detector: config registers, front, queue, back
// depends on phpd_pkg, phpd_front, phpd_queue and phpd_back
//
// usage:
//   s_* carries one request per converter sample: raw reading and a microsecond
//   timestamp. the front part takes a request in F_IDLE and evaluates it in the
//   next cycle in F_EVAL; s_tready is high only in F_IDLE, so no new sample is
//   taken while one is in evaluation. a sample that closes a scan window puts the
//   hit peak in a short queue; if the queue is full the front holds that sample
//   until a slot frees. the back part pops a peak and computes the velocity with
//   a restoring divider, one quotient bit a cycle, and skips the divider for
//   saturated or minimum cases; the result then sits on m_* until m_tready takes
//   it. the closing sample's peak passes through the queue, then B_IDLE, B_DIV
//   where needed and B_OUT, which drives m_tvalid. while the receiver stalls,
//   the front keeps taking samples until a closing sample finds the queue full.
//   cfg_we writes register cfg_index (trigger, full scale, scan, mask window)
//   and must only be used while no hit is in flight.
//   rst (synchronous) restores register defaults, idles the scan, clears the
//   queue and sets the last hit end time to zero.
module piezo_hit_peak_detector #(
  parameter int QUEUE_DEPTH = phpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [phpd_pkg::IN_W-1:0]      s_tdata,   // raw_sample[11:0], now_us[75:12], zero
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [phpd_pkg::OUT_W-1:0]     m_tdata,   // hit_velocity[6:0], zero
  input  logic                           cfg_we,
  input  logic [phpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [phpd_pkg::WIN_W-1:0]     cfg_wdata
);

  phpd_pkg::cfg_t               cfg;
  phpd_pkg::q_status_t          q_stat;
  logic                         q_push;
  logic                         q_pop;
  logic [phpd_pkg::LEVEL_W-1:0] q_wdata;
  logic [phpd_pkg::LEVEL_W-1:0] q_rdata;
  logic [phpd_pkg::LEVEL_W-1:0] hit_velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level    <= phpd_pkg::TRIGGER_RESET;
      cfg.full_scale_level <= phpd_pkg::FULL_SCALE_RESET;
      cfg.scan_window_us   <= phpd_pkg::SCAN_RESET;
      cfg.mask_window_us   <= phpd_pkg::MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        phpd_pkg::REG_TRIGGER:    cfg.trigger_level    <= cfg_wdata[phpd_pkg::LEVEL_W-1:0];
        phpd_pkg::REG_FULL_SCALE: cfg.full_scale_level <= cfg_wdata[phpd_pkg::LEVEL_W-1:0];
        phpd_pkg::REG_SCAN:       cfg.scan_window_us   <= cfg_wdata;
        phpd_pkg::REG_MASK:       cfg.mask_window_us   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  phpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .raw_sample (s_tdata[phpd_pkg::RAW_W-1:0]),
    .now_us     (s_tdata[phpd_pkg::RAW_W+phpd_pkg::TIME_W-1:phpd_pkg::RAW_W]),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  phpd_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (phpd_pkg::LEVEL_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  phpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .hit_velocity (hit_velocity)
  );

  assign m_tdata = {1'b0, hit_velocity};

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("peak pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("peak popped from an empty queue");

  a_vel_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[phpd_pkg::LEVEL_W-1:0] != '0 && m_tdata[phpd_pkg::OUT_W-1] == 1'b0))
    else $error("velocity out of range");

endmodule

### tb/tb.sv
// testbench for piezo_hit_peak_detector: directed and random samples, checked against a predictor
// depends on phpd_pkg and the piezo_hit_peak_detector rtl
`timescale 1ns / 100ps

module tb;
  import phpd_pkg::*;

  class hit_scoreboard;
    logic [LEVEL_W-1:0] trigger_lvl;
    logic [LEVEL_W-1:0] full_lvl;
    logic [WIN_W-1:0]   scan_us;
    logic [WIN_W-1:0]   mask_us;
    bit                 scanning;
    logic [LEVEL_W-1:0] peak_lvl;
    logic [TIME_W-1:0]  start_t;
    logic [TIME_W-1:0]  end_t;
    logic [LEVEL_W-1:0] velocity_q[$];
    int                 mismatches;

    function new();
      trigger_lvl = TRIGGER_RESET;
      full_lvl    = FULL_SCALE_RESET;
      scan_us     = SCAN_RESET;
      mask_us     = MASK_RESET;
      scanning    = 1'b0;
      peak_lvl    = '0;
      start_t     = '0;
      end_t       = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
      case (idx)
        REG_TRIGGER:    trigger_lvl = val[LEVEL_W-1:0];
        REG_FULL_SCALE: full_lvl    = val[LEVEL_W-1:0];
        REG_SCAN:       scan_us     = val;
        REG_MASK:       mask_us     = val;
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] curve(logic [LEVEL_W-1:0] pk);
      int unsigned v;
      if (full_lvl <= trigger_lvl) return LEVEL_MAX;
      if (pk <= trigger_lvl) return VEL_MIN;
      v = (127 * (int'(pk) - int'(trigger_lvl))) / (int'(full_lvl) - int'(trigger_lvl));
      if (v < 1) v = 1;
      if (v > 127) v = 127;
      return v[LEVEL_W-1:0];
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw, logic [TIME_W-1:0] now);
      int unsigned lvl;
      lvl = raw;
      lvl = lvl * 127 / 4095;
      if (!scanning && lvl > trigger_lvl) begin
        if (now - end_t < {44'd0, mask_us}) return;
        start_t  = now;
        peak_lvl = lvl[LEVEL_W-1:0];
        scanning = 1'b1;
      end
      if (scanning) begin
        if (lvl > peak_lvl) peak_lvl = lvl[LEVEL_W-1:0];
        if (now - start_t >= {44'd0, scan_us}) begin
          velocity_q.push_back(curve(peak_lvl));
          end_t    = now;
          scanning = 1'b0;
        end
      end
    endfunction

    function void check_velocity(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (velocity_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected velocity %0d", got);
        return;
      end
      want = velocity_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("velocity mismatch: expected %0d got %0d", want, got);
      end
    endfunction

    function int pending();
      return velocity_q.size();
    endfunction

    function void close_out();
      if (velocity_q.size() != 0) begin
        $display("%0d velocities never arrived", velocity_q.size());
        mismatches += velocity_q.size();
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  hit_scoreboard     sb;
  logic [TIME_W-1:0] now_cursor = '0;
  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                cycle_count = 0;

  piezo_hit_peak_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_velocity(m_tdata[LEVEL_W-1:0]);
  end

  task automatic send_sample(input int unsigned raw, input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, now, raw[RAW_W-1:0]};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(raw[RAW_W-1:0], now);
    now_cursor = now;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[WIN_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, val[WIN_W-1:0]);
  endtask

  task automatic load_cfg(input int unsigned trig, fs, scan, mask);
    put_reg(REG_TRIGGER, trig);
    put_reg(REG_FULL_SCALE, fs);
    put_reg(REG_SCAN, scan);
    put_reg(REG_MASK, mask);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned raw_above_trigger();
    int unsigned lo;
    if (sb.trigger_lvl >= LEVEL_MAX) return $urandom_range(0, 4095);
    lo = ((int'(sb.trigger_lvl) + 1) * 4095 + 126) / 127;
    return $urandom_range(lo, 4095);
  endfunction

  function automatic int unsigned pick_raw();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      4:       return $urandom_range(0, 400);
      5:       return raw_above_trigger();
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // hits (start past the mask or just short of it, samples inside the scan, a closing sample)
  // mixed with noise: random levels, backward and far-off timestamps
  task automatic run_hits(input int n_items);
    int                sent;
    int                k;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] t0;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        t = now_cursor + $urandom_range(1, 40);
        if (t - sb.end_t < {44'd0, sb.mask_us}) begin
          t = sb.end_t + sb.mask_us;
          if ($urandom_range(0, 3) == 0) t = t - 1;
          else t = t + $urandom_range(0, 3);
        end
        t0 = t;
        send_sample(raw_above_trigger(), t);
        k = $urandom_range(0, 4);
        repeat (k) begin
          t = t + $urandom_range(0, sb.scan_us / 4);
          send_sample($urandom_range(0, 4095), t);
        end
        send_sample(pick_raw(), t0 + sb.scan_us + $urandom_range(0, 2));
        sent += k + 2;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) begin
          case ($urandom_range(0, 9))
            0:       t = {$urandom, $urandom};
            1:       t = now_cursor - $urandom_range(1, 5000);
            default: t = now_cursor + $urandom_range(0, sb.scan_us / 2 + sb.mask_us / 8 + 2);
          endcase
          send_sample(pick_raw(), t);
        end
        sent += k;
      end
    end
  endtask

  task automatic phase_cfg(input int p);
    int unsigned t;
    case (p)
      0: load_cfg(20, 27, 6300, 24600);
      1: load_cfg(0, 127, 0, 0);
      2: load_cfg(126, 0, 1048575, 1048575);
      3: begin
        t = $urandom_range(0, 60);
        load_cfg(t, t, $urandom_range(0, 3000), $urandom_range(0, 3000));
      end
      default: load_cfg($urandom_range(0, 110), $urandom_range(0, 127),
                        (p % 2) ? $urandom_range(0, 1048575) : $urandom_range(0, 4000),
                        $urandom_range(0, 8000));
    endcase
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: mask from time zero, scan and mask boundaries
    send_sample(4095, 100);
    send_sample(0, 0);
    send_sample(4095, 30000);
    send_sample(2000, 36299);
    send_sample(1000, 36300);
    send_sample(4095, 36301);
    send_sample(4095, 60900);
    send_sample(700, 67200);
    wait_idle();
    // zero scan: start and end in one sample
    load_cfg(0, 127, 0, 0);
    send_sample(33, 70000);
    send_sample(4095, 70001);
    send_sample(0, 70002);
    send_sample(4094, 70003);
    wait_idle();
    // full scale below trigger saturates
    load_cfg(10, 5, 100, 0);
    send_sample(2048, 80000);
    send_sample(0, 80100);
    wait_idle();
    // trigger raised while a hit is open
    load_cfg(20, 27, 1000, 0);
    send_sample(678, 90000);
    wait_idle();
    load_cfg(100, 120, 1000, 0);
    send_sample(0, 91000);
    wait_idle();
    load_cfg(127, 127, 10, 0);
    send_sample(4095, 100000);
    wait_idle();
    // timestamp wrap and a timestamp going backwards
    load_cfg(20, 27, 1000, 0);
    send_sample(4095, 64'hFFFF_FFFF_FFFF_FFF0);
    send_sample(100, 64'd5);
    send_sample(100, 64'd2000);
    send_sample(4095, 64'h8000_0000_0000_0000);
    send_sample(4095, 64'h7FFF_FFFF_FFFF_FFFF);
    wait_idle();
    load_cfg(20, 27, 1048575, 1048575);
    send_sample(4095, 64'd3000000);
    send_sample(4095, 64'd3000000 + 64'd1048575);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      phase_cfg(p);
      case (p % 4)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 61; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 61; end
        default: begin tx_idle_pct <= 21; rx_stall_pct <= 21; end
      endcase
      @(posedge clk);
      run_hits(120);
      wait_idle();
      run_hits(120);
      wait_idle();
    end

    // every sample closes a hit while the receiver holds off, so the block backs up
    load_cfg(0, 127, 0, 0);
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    hold_req     <= hold_req + 1;
    @(posedge clk);
    repeat (40) send_sample($urandom_range(1000, 4095), now_cursor + 1);
    wait_idle();

    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### piezo_hit_peak_detector.f
sv/phpd_pkg.sv
sv/phpd_front.sv
sv/phpd_queue.sv
sv/phpd_back.sv
sv/piezo_hit_peak_detector.sv
tb/tb.sv
